// File: hw/rtl/tiff_stream_writer_assert.svh
// Assertion macros for the TIFF stream writer.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef TIFF_STREAM_WRITER_ASSERT_SVH
`define TIFF_STREAM_WRITER_ASSERT_SVH

// same-cycle implication
`define TSW_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tiff_stream_writer: assertion failed");

// next-cycle implication
`define TSW_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tiff_stream_writer: assertion failed");

`endif

// File: hw/rtl/tsw_pkg.sv
// Shared types, codes and constants of the TIFF stream writer.
// No dependencies.
package tsw_pkg;

	localparam int unsigned CMD_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_PIXEL  = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_BITS = 2'd1,
		ST_COUNT    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_BITS   = 3'd2,
		REG_DPI    = 3'd3,
		REG_PHOTO  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_PIXEL  = 2'd1,
		CMD_DIR    = 2'd2,
		CMD_ERROR  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [5:0]  sample_bits;
		logic [15:0] resolution_dpi;
		logic [15:0] photometric_code;
	} cfg_t;

	// data holds the pixel byte or the byte total latched at start
	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  status;
		logic [31:0] data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  valid_bytes;
		logic [1:0]  status;
		logic        last;
	} res_t;

	localparam logic [31:0] HDR_WORD0      = 32'h002A_4949; // "II", 42
	localparam logic [31:0] HDR_BYTES      = 32'd8;
	localparam logic [31:0] DIR_BYTES      = 32'd178;
	localparam logic [31:0] RATIONAL_BYTES = 32'd8;

	localparam logic [2:0] VB_NONE  = 3'd0;
	localparam logic [2:0] VB_PIXEL = 3'd1;
	localparam logic [2:0] VB_TAIL  = 3'd2;
	localparam logic [2:0] VB_FULL  = 3'd4;

	localparam int unsigned TAG_COUNT = 13;
	localparam logic [5:0]  TAG_LAST_WORD = 6'd39;
	localparam logic [5:0]  DIR_LAST_WORD = 6'd44;

	localparam logic [15:0] TAG_ID [TAG_COUNT] = '{
		16'd254, 16'd256, 16'd257, 16'd258, 16'd259, 16'd262, 16'd273,
		16'd277, 16'd278, 16'd279, 16'd282, 16'd283, 16'd296
	};

	localparam logic [15:0] TAG_TYPE [TAG_COUNT] = '{
		16'd4, 16'd4, 16'd4, 16'd3, 16'd3, 16'd3, 16'd4,
		16'd3, 16'd4, 16'd4, 16'd5, 16'd5, 16'd3
	};

	function automatic logic bits_ok(input logic [5:0] sb);
		return (sb == 6'd8) || (sb == 6'd16) || (sb == 6'd32);
	endfunction

endpackage

// File: hw/rtl/tsw_fifo.sv
// Small first-in first-out queue of registers, used for commands and results.
// No package dependencies. DEPTH must be a power of two, at least 2.
module tsw_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int unsigned AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/tsw_front.sv
// Front end: accepts items, keeps the byte count and file state, classifies
// each item into a command for the back end. Depends on tsw_pkg.
module tsw_front
	import tsw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       push,
	output logic       full,
	input  logic [1:0] opcode,
	input  logic [7:0] pixel_byte,
	input  logic       cmd_full,
	output logic       cmd_push,
	output cmd_t       cmd
);
	logic [31:0] count_q;
	logic [31:0] total_q;
	logic        header_sent_q;
	logic        accept;
	logic        ok;
	logic [31:0] area;
	logic [31:0] total;
	logic [1:0]  fin_status;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign ok     = bits_ok(cfg.sample_bits);
	assign area   = {16'd0, cfg.image_width} * {16'd0, cfg.image_height};

	// sample bits are 8, 16 or 32 whenever the total is used
	always_comb begin
		case (cfg.sample_bits)
			6'd16:   total = {area[30:0], 1'b0};
			6'd32:   total = {area[29:0], 2'b00};
			default: total = area;
		endcase
	end

	always_comb begin
		if (!ok) begin
			fin_status = ST_BAD_BITS;
		end else if (!header_sent_q || (count_q != total_q)) begin
			fin_status = ST_COUNT;
		end else begin
			fin_status = ST_OK;
		end
	end

	always_comb begin
		cmd_push = 1'b0;
		cmd      = '{kind: CMD_PIXEL, status: ST_OK, data: '0};
		case (op_t'(opcode))
			OP_START: begin
				cmd_push = accept;
				if (ok) begin
					cmd.kind = CMD_HEADER;
					cmd.data = total;
				end else begin
					cmd.kind   = CMD_ERROR;
					cmd.status = ST_BAD_BITS;
				end
			end
			OP_PIXEL: begin
				cmd_push = accept;
				cmd.data = {24'd0, pixel_byte};
			end
			OP_FINISH: begin
				cmd_push = accept;
				cmd.data = total_q;
				if (fin_status == ST_OK) begin
					cmd.kind = CMD_DIR;
				end else begin
					cmd.kind   = CMD_ERROR;
					cmd.status = fin_status;
				end
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			total_q       <= '0;
			header_sent_q <= 1'b0;
		end else if (accept) begin
			case (op_t'(opcode))
				OP_START: begin
					count_q       <= '0;
					header_sent_q <= ok;
					if (ok) begin
						total_q <= total;
					end
				end
				OP_PIXEL: begin
					count_q <= count_q + 32'd1;
				end
				OP_FINISH: begin
					count_q       <= '0;
					header_sent_q <= 1'b0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/tsw_back.sv
// Back end: turns commands into result beats, one per cycle unless stalled,
// walking header and directory layouts with a word sequencer. Needs tsw_pkg.
module tsw_back
	import tsw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_empty,
	output logic cmd_pop,
	input  cmd_t cmd,
	input  logic out_full,
	output logic out_push,
	output res_t res
);
	localparam logic [3:0] TAG_LAST = 4'(TAG_COUNT - 1);

	logic        busy_q;
	cmd_kind_t   kind_q;
	logic [31:0] total_q;
	logic [5:0]  word_q;
	logic [1:0]  phase_q;
	logic [3:0]  tag_q;

	cmd_kind_t   cur_kind;
	logic [31:0] cur_total;
	logic [5:0]  cur_word;
	logic [1:0]  cur_phase;
	logic [3:0]  cur_tag;
	logic [31:0] dir_off;
	logic [31:0] xres_off;
	logic [31:0] yres_off;
	logic [31:0] tag_val;
	logic [15:0] next_id;
	logic [31:0] tag_word;
	logic [31:0] dir_word;

	assign cur_kind  = busy_q ? kind_q  : cmd.kind;
	assign cur_total = busy_q ? total_q : cmd.data;
	assign cur_word  = busy_q ? word_q  : '0;
	assign cur_phase = busy_q ? phase_q : '0;
	assign cur_tag   = busy_q ? tag_q   : '0;

	assign cmd_pop  = !busy_q && !cmd_empty && !out_full;
	assign out_push = !out_full && (busy_q || !cmd_empty);

	assign dir_off  = cur_total + HDR_BYTES;
	assign xres_off = dir_off + DIR_BYTES;
	assign yres_off = xres_off + RATIONAL_BYTES;

	// value field of each directory entry, in tag order
	always_comb begin
		case (cur_tag)
			4'd1:    tag_val = {16'd0, cfg.image_width};
			4'd2:    tag_val = {16'd0, cfg.image_height};
			4'd3:    tag_val = {26'd0, cfg.sample_bits};
			4'd4:    tag_val = 32'd1;                 // no compression
			4'd5:    tag_val = {16'd0, cfg.photometric_code};
			4'd6:    tag_val = HDR_BYTES;             // strip offset
			4'd7:    tag_val = 32'd1;                 // samples per pixel
			4'd8:    tag_val = {16'd0, cfg.image_height};
			4'd9:    tag_val = cur_total;
			4'd10:   tag_val = xres_off;
			4'd11:   tag_val = yres_off;
			4'd12:   tag_val = 32'd2;                 // resolution unit: inch
			default: tag_val = '0;
		endcase
	end

	assign next_id = (cur_tag == TAG_LAST) ? 16'd0 : TAG_ID[4'(cur_tag + 4'd1)];

	// entries start at byte 2, so each 12-byte entry spans three words
	// offset by a half word
	always_comb begin
		case (cur_phase)
			2'd0:    tag_word = {16'd1, TAG_TYPE[cur_tag]};
			2'd1:    tag_word = {tag_val[15:0], 16'd0};
			default: tag_word = {next_id, tag_val[31:16]};
		endcase
	end

	always_comb begin
		if (cur_word == '0) begin
			dir_word = {TAG_ID[0], 16'(TAG_COUNT)};
		end else if (cur_word <= TAG_LAST_WORD) begin
			dir_word = tag_word;
		end else begin
			// next pointer high half, then the two dpi/1 rationals
			case (cur_word)
				6'd40:   dir_word = {cfg.resolution_dpi, 16'd0};
				6'd41:   dir_word = {16'd1, 16'd0};
				6'd42:   dir_word = {cfg.resolution_dpi, 16'd0};
				6'd43:   dir_word = {16'd1, 16'd0};
				default: dir_word = '0;
			endcase
		end
	end

	always_comb begin
		res = '{out_word: '0, valid_bytes: VB_NONE, status: ST_OK, last: 1'b1};
		case (cur_kind)
			CMD_HEADER: begin
				res.out_word    = (cur_word == '0) ? HDR_WORD0 : dir_off;
				res.valid_bytes = VB_FULL;
				res.last        = (cur_word != '0);
			end
			CMD_PIXEL: begin
				res.out_word    = {24'd0, cmd.data[7:0]};
				res.valid_bytes = VB_PIXEL;
			end
			CMD_DIR: begin
				res.out_word    = dir_word;
				res.last        = (cur_word == DIR_LAST_WORD);
				res.valid_bytes = res.last ? VB_TAIL : VB_FULL;
			end
			default: begin
				res.status = cmd.status;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_push && !busy_q) begin
			kind_q  <= cur_kind;
			total_q <= cur_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			word_q  <= '0;
			phase_q <= '0;
			tag_q   <= '0;
		end else if (out_push) begin
			busy_q <= !res.last;
			word_q <= cur_word + 6'd1;
			if (cur_word == '0) begin
				phase_q <= '0;
				tag_q   <= '0;
			end else if (cur_phase == 2'd2) begin
				phase_q <= '0;
				tag_q   <= cur_tag + 4'd1;
			end else begin
				phase_q <= cur_phase + 2'd1;
			end
		end
	end

endmodule

// File: hw/rtl/tiff_stream_writer.sv
// Little-endian single-strip TIFF stream writer. Items enter through a
// push/full port, results leave through an empty/pop port as 32-bit words
// with a valid-byte count. Pixel bytes flow at one per clock while the
// result queue has room; a legal start item holds the back-end word sequencer
// for two header words, a passing finish item for 45 directory words (one word per
// cycle unless stalled), while up to CMD_DEPTH more items queue. Results
// pass the command queue, then the result queue. The user writes registers
// via cfg_we/cfg_index/cfg_data only while no item is in flight; the block
// does not enforce this. Depends on tsw_pkg, tsw_front, tsw_back, tsw_fifo.
module tiff_stream_writer
	import tsw_pkg::*;
#(
	parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  pixel_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] out_word,
	output logic [2:0]  valid_bytes,
	output logic [1:0]  status,
	output logic        last
);
	`include "tiff_stream_writer_assert.svh"

	cfg_t cfg_q;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic out_push;
	logic out_full;
	res_t res_in;
	res_t res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width      <= 16'd1;
			cfg_q.image_height     <= 16'd1;
			cfg_q.sample_bits      <= 6'd8;
			cfg_q.resolution_dpi   <= 16'd72;
			cfg_q.photometric_code <= 16'd1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:  cfg_q.image_width      <= cfg_data;
				REG_HEIGHT: cfg_q.image_height     <= cfg_data;
				REG_BITS:   cfg_q.sample_bits      <= cfg_data[5:0];
				REG_DPI:    cfg_q.resolution_dpi   <= cfg_data;
				REG_PHOTO:  cfg_q.photometric_code <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	tsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.pixel_byte (pixel_byte),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	tsw_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (cmd_full),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_out)
	);

	tsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_out),
		.out_full  (out_full),
		.out_push  (out_push),
		.res       (res_in)
	);

	tsw_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign out_word    = res_out.out_word;
	assign valid_bytes = res_out.valid_bytes;
	assign status      = res_out.status;
	assign last        = res_out.last;

	`TSW_ASSERT_IMP(a_out_no_overflow, out_push, !out_full)
	`TSW_ASSERT_NEXT(a_out_beat_held, out_push, !empty)
	`TSW_ASSERT_IMP(a_error_beat_form, !empty && status != ST_OK, valid_bytes == VB_NONE && last)
	`TSW_ASSERT_IMP(a_tail_is_last, !empty && valid_bytes == VB_TAIL, last)

endmodule

// File: dv/tiff_stream_writer_test.sv
`timescale 1ns / 1ps
// Self-checking test of tiff_stream_writer: directed files, then random files.
// Depends on tsw_pkg and the tiff_stream_writer RTL.
module tiff_stream_writer_test
	import tsw_pkg::*;
();

	localparam logic [1:0]  OP_NONE      = 2'd3; // no operation, dropped by the block
	localparam logic [2:0]  REG_UNUSED   = 3'd7;
	localparam logic [31:0] TIFF_MAGIC   = 32'h002A_4949;
	localparam logic [31:0] HEADER_LEN   = 32'd8;
	localparam logic [31:0] IFD_LEN      = 32'd178;
	localparam logic [31:0] RATIONAL_LEN = 32'd8;
	localparam logic [15:0] DIR_ENTRIES  = 16'd13;
	localparam int          IFD_WORDS    = 45;
	localparam int          SETTLE       = 10;
	localparam int          RANDOM_UNTIL = 240;

	localparam logic [15:0] T_SHORT    = 16'd3;
	localparam logic [15:0] T_LONG     = 16'd4;
	localparam logic [15:0] T_RATIONAL = 16'd5;

	localparam logic [15:0] ID_SUBFILE   = 16'd254;
	localparam logic [15:0] ID_WIDTH     = 16'd256;
	localparam logic [15:0] ID_LENGTH    = 16'd257;
	localparam logic [15:0] ID_BITS      = 16'd258;
	localparam logic [15:0] ID_COMPRESS  = 16'd259;
	localparam logic [15:0] ID_PHOTO     = 16'd262;
	localparam logic [15:0] ID_STRIP_OFS = 16'd273;
	localparam logic [15:0] ID_SPP       = 16'd277;
	localparam logic [15:0] ID_ROWS      = 16'd278;
	localparam logic [15:0] ID_STRIP_LEN = 16'd279;
	localparam logic [15:0] ID_XRES      = 16'd282;
	localparam logic [15:0] ID_YRES      = 16'd283;
	localparam logic [15:0] ID_RES_UNIT  = 16'd296;

	localparam cfg_t CFG_RESET = '{16'd1, 16'd1, 6'd8, 16'd72, 16'd1};

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [2:0]  cfg_index  = REG_WIDTH;
	logic [15:0] cfg_data   = 16'h0000;
	logic        push       = 1'b0;
	logic        full;
	logic [1:0]  opcode     = OP_START;
	logic [7:0]  pixel_byte = 8'h00;
	logic        empty;
	logic        pop        = 1'b0;
	logic [31:0] out_word;
	logic [2:0]  valid_bytes;
	logic [1:0]  status;
	logic        last;

	// mirror of the block's registers and file state
	cfg_t        cur_cfg       = CFG_RESET;
	logic [31:0] px_count      = '0;
	logic [31:0] total_latched = '0;
	logic        hdr_open      = 1'b0;

	res_t        tiff_words_due[$];
	logic [15:0] dir_half[$];
	int          n_errors   = 0;
	int          n_items    = 0;
	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	int unsigned rx_hold    = 0;

	tiff_stream_writer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.pixel_byte  (pixel_byte),
		.empty       (empty),
		.pop         (pop),
		.out_word    (out_word),
		.valid_bytes (valid_bytes),
		.status      (status),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit bits_legal();
		return cur_cfg.sample_bits == 6'd8 || cur_cfg.sample_bits == 6'd16 ||
			cur_cfg.sample_bits == 6'd32;
	endfunction

	function automatic void due(input logic [31:0] w, input logic [2:0] vb,
			input logic [1:0] st, input logic lst);
		res_t r;
		r.out_word    = w;
		r.valid_bytes = vb;
		r.status      = st;
		r.last        = lst;
		tiff_words_due.insert(tiff_words_due.size(), r);
	endfunction

	function automatic void add_half(input logic [15:0] h);
		dir_half.insert(dir_half.size(), h);
	endfunction

	function automatic void add32(input logic [31:0] v);
		add_half(v[15:0]);
		add_half(v[31:16]);
	endfunction

	function automatic void add_entry(input logic [15:0] id, input logic [15:0] typ,
			input logic [31:0] v);
		add_half(id);
		add_half(typ);
		add32(32'd1);
		add32(v);
	endfunction

	// directory words for a good finish, from the total latched at start
	function automatic void build_ifd();
		logic [31:0] dir_off, xres, yres;
		dir_off = total_latched + HEADER_LEN;
		xres    = dir_off + IFD_LEN;
		yres    = xres + RATIONAL_LEN;
		dir_half.delete();
		add_half(DIR_ENTRIES);
		add_entry(ID_SUBFILE,   T_LONG,     32'd0);
		add_entry(ID_WIDTH,     T_LONG,     32'(cur_cfg.image_width));
		add_entry(ID_LENGTH,    T_LONG,     32'(cur_cfg.image_height));
		add_entry(ID_BITS,      T_SHORT,    32'(cur_cfg.sample_bits));
		add_entry(ID_COMPRESS,  T_SHORT,    32'd1);
		add_entry(ID_PHOTO,     T_SHORT,    32'(cur_cfg.photometric_code));
		add_entry(ID_STRIP_OFS, T_LONG,     HEADER_LEN);
		add_entry(ID_SPP,       T_SHORT,    32'd1);
		add_entry(ID_ROWS,      T_LONG,     32'(cur_cfg.image_height));
		add_entry(ID_STRIP_LEN, T_LONG,     total_latched);
		add_entry(ID_XRES,      T_RATIONAL, xres);
		add_entry(ID_YRES,      T_RATIONAL, yres);
		add_entry(ID_RES_UNIT,  T_SHORT,    32'd2);
		add32(32'd0);
		add32(32'(cur_cfg.resolution_dpi));
		add32(32'd1);
		add32(32'(cur_cfg.resolution_dpi));
		add32(32'd1);
		add_half(16'h0000); // pads the two-byte tail word
		for (int k = 0; k < IFD_WORDS; k++) begin
			if (k == IFD_WORDS - 1)
				due({dir_half[2*k+1], dir_half[2*k]}, VB_TAIL, ST_OK, 1'b1);
			else
				due({dir_half[2*k+1], dir_half[2*k]}, VB_FULL, ST_OK, 1'b0);
		end
	endfunction

	function automatic void predict_item(input logic [1:0] op, input logic [7:0] b);
		logic [63:0] prod;
		status_t st;
		case (op)
			OP_START: begin
				px_count = '0;
				if (!bits_legal()) begin
					hdr_open = 1'b0;
					due('0, VB_NONE, ST_BAD_BITS, 1'b1);
				end else begin
					prod = 64'(cur_cfg.image_width) * 64'(cur_cfg.image_height) *
						64'(cur_cfg.sample_bits);
					total_latched = prod[34:3];
					hdr_open = 1'b1;
					due(TIFF_MAGIC, VB_FULL, ST_OK, 1'b0);
					due(total_latched + HEADER_LEN, VB_FULL, ST_OK, 1'b1);
				end
			end
			OP_PIXEL: begin
				px_count = px_count + 32'd1;
				due(32'(b), VB_PIXEL, ST_OK, 1'b1);
			end
			OP_FINISH: begin
				if (!bits_legal())
					st = ST_BAD_BITS;
				else if (!hdr_open || px_count != total_latched)
					st = ST_COUNT;
				else
					st = ST_OK;
				hdr_open = 1'b0;
				px_count = '0;
				if (st != ST_OK)
					due('0, VB_NONE, st, 1'b1);
				else
					build_ifd();
			end
			default: ;
		endcase
	endfunction

	// result side: compare each popped beat, then decide the next pop
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			if (tiff_words_due.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected beat: word %h valid %0d status %0d last %0d",
						out_word, valid_bytes, status, last);
			end else begin
				want = tiff_words_due.pop_front();
				if (want.out_word !== out_word || want.valid_bytes !== valid_bytes ||
						want.status !== status || want.last !== last) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: word %h/%h valid %0d/%0d status %0d/%0d last %0d/%0d",
							want.out_word, out_word, want.valid_bytes, valid_bytes,
							want.status, status, want.last, last);
				end
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (rx_idle_on)
				rx_hold = pause_len();
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		int unsigned gap;
		push       <= 1'b1;
		opcode     <= op;
		pixel_byte <= b;
		do @(posedge clk); while (full);
		predict_item(op, b);
		if (op != OP_NONE)
			n_items++;
		gap = tx_idle_on ? pause_len() : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_pixels(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_item(OP_PIXEL, 8'($urandom));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (tiff_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write all five registers; upper data bits above a narrow register are random
	task automatic write_regs(input cfg_t c, input bit poke_unused);
		for (int i = 0; i < 6; i++) begin
			if (i == 5 && !poke_unused)
				break;
			cfg_we <= 1'b1;
			case (i)
				0: begin cfg_index <= REG_WIDTH;  cfg_data <= c.image_width; end
				1: begin cfg_index <= REG_HEIGHT; cfg_data <= c.image_height; end
				2: begin cfg_index <= REG_BITS;   cfg_data <= {10'($urandom), c.sample_bits}; end
				3: begin cfg_index <= REG_DPI;    cfg_data <= c.resolution_dpi; end
				4: begin cfg_index <= REG_PHOTO;  cfg_data <= c.photometric_code; end
				default: begin cfg_index <= REG_UNUSED; cfg_data <= 16'($urandom); end
			endcase
			@(posedge clk);
		end
		cur_cfg = c;
		cfg_we <= 1'b0;
	endtask

	task automatic test_stray_and_default();
		send_item(OP_PIXEL, 8'hFF);   // before any start
		send_item(OP_FINISH, 8'h00);  // finish with no file open
		send_item(OP_NONE, 8'hFF);
		send_item(OP_START, 8'h00);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_FINISH, 8'hFF);
		wait_idle();
	endtask

	task automatic test_bad_sample_bits();
		write_regs('{16'd3, 16'd2, 6'd0, 16'd96, 16'd2}, 1'b0);
		send_item(OP_START, 8'h00);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
		write_regs('{16'd3, 16'd2, 6'd63, 16'd96, 16'd2}, 1'b0);
		send_item(OP_START, 8'h00);
		wait_idle();
	endtask

	task automatic test_extreme_regs();
		// zero-size image, largest tag values
		write_regs('{16'd0, 16'hFFFF, 6'd32, 16'hFFFF, 16'hFFFF}, 1'b0);
		send_item(OP_START, 8'h00);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
		// byte total wraps; no way to send it, so the finish fails
		write_regs('{16'hFFFF, 16'hFFFF, 6'd32, 16'd1, 16'd0}, 1'b0);
		send_item(OP_START, 8'h00);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
		write_regs('{16'hFFFF, 16'd0, 6'd16, 16'd0, 16'd0}, 1'b0);
		send_item(OP_START, 8'h00);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
	endtask

	task automatic test_short_file();
		write_regs('{16'd2, 16'd1, 6'd8, 16'd150, 16'd1}, 1'b0);
		send_item(OP_START, 8'h00);
		send_pixels(1);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
	endtask

	task automatic test_regs_mid_file();
		write_regs('{16'd2, 16'd2, 6'd8, 16'd300, 16'd2}, 1'b0);
		send_item(OP_START, 8'h00);
		wait_idle();
		// tags follow the new values, strip length the latched total
		write_regs('{16'd7, 16'd5, 6'd8, 16'd600, 16'd0}, 1'b1);
		send_pixels(4);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
		send_item(OP_START, 8'h00);
		wait_idle();
		write_regs('{16'd7, 16'd5, 6'd24, 16'd600, 16'd0}, 1'b0);
		send_item(OP_FINISH, 8'h00);
		wait_idle();
	endtask

	task automatic run_random_file();
		int unsigned kind, n;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			send_item(OP_START, 8'($urandom));
			n = hdr_open ? total_latched : $urandom_range(0, 3);
			for (int unsigned i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(OP_NONE, 8'($urandom));
				send_item(OP_PIXEL, 8'($urandom));
			end
			send_item(OP_FINISH, 8'($urandom));
		end else if (kind < 87) begin
			send_item(OP_START, 8'($urandom));
			n = total_latched;
			if (n == 0 || $urandom_range(0, 1) == 0)
				n = n + 1;
			else
				n = n - 1;
			send_pixels(n);
			send_item(OP_FINISH, 8'($urandom));
		end else if (kind < 93) begin
			send_pixels($urandom_range(0, 3));
			send_item(OP_FINISH, 8'($urandom));
		end else begin
			// restart in mid-file clears the count
			send_item(OP_START, 8'($urandom));
			send_pixels($urandom_range(1, 3));
			send_item(OP_START, 8'($urandom));
			send_pixels(total_latched);
			send_item(OP_FINISH, 8'($urandom));
		end
	endtask

	task automatic test_random_files();
		cfg_t c;
		while (n_items < RANDOM_UNTIL) begin
			wait_idle();
			c.image_width  = 16'($urandom_range(0, 4));
			c.image_height = 16'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c.sample_bits = 6'd8;
				4, 5:       c.sample_bits = 6'd16;
				6, 7:       c.sample_bits = 6'd32;
				default:    c.sample_bits = 6'($urandom_range(0, 63));
			endcase
			c.resolution_dpi   = 16'($urandom);
			c.photometric_code = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : 16'($urandom);
			write_regs(c, $urandom_range(0, 9) == 0);
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(1, 3)) run_random_file();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stray_and_default();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_bad_sample_bits();
		test_extreme_regs();
		test_short_file();
		test_regs_mid_file();
		test_random_files();
		wait_idle();
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tsw_pkg.sv
hw/rtl/tsw_fifo.sv
hw/rtl/tsw_front.sv
hw/rtl/tsw_back.sv
hw/rtl/tiff_stream_writer.sv
dv/tiff_stream_writer_test.sv
